[src/lesq_pkg.sv]
// Shared types and constants for the largest empty square scanner.
// Used by the channel interfaces, the top level and the port checker.
package lesq_pkg;

  // Default map limits handed to the top level.
  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_ROWS = 1024;

  // Field widths fixed by the block's external format.
  localparam int CHAR_W     = 8;
  localparam int COUNT_W    = 11;
  localparam int SIZE_OUT_W = 11;
  localparam int POS_OUT_W  = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT     = 2'd0,
    REG_COLUMN_COUNT  = 2'd1,
    REG_OBSTACLE_CODE = 2'd2,
    REG_FREE_CODE     = 2'd3
  } cfg_reg_t;

  // Register values after reset.
  localparam logic [COUNT_W-1:0] RST_ROW_COUNT     = 11'd1024;
  localparam logic [COUNT_W-1:0] RST_COLUMN_COUNT  = 11'd1024;
  localparam logic [CHAR_W-1:0]  RST_OBSTACLE_CODE = 8'd111;
  localparam logic [CHAR_W-1:0]  RST_FREE_CODE     = 8'd46;

  // One result item.
  typedef struct packed {
    logic [SIZE_OUT_W-1:0] square_size;
    logic [SIZE_OUT_W-1:0] best_size;
    logic [POS_OUT_W-1:0]  best_row;
    logic [POS_OUT_W-1:0]  best_col;
    logic                  bad_char;
    logic                  map_done;
  } out_item_t;

endpackage

[src/lesq_if.sv]
// Valid/ready channel interfaces for map characters in and scan results out.
// Depends on lesq_pkg for the field widths and the result item type.
interface lesq_in_if;
  logic                        valid;
  logic                        ready;
  logic [lesq_pkg::CHAR_W-1:0] cell_char;

  modport source (output valid, output cell_char, input ready);
  modport sink (input valid, input cell_char, output ready);
endinterface

interface lesq_out_if;
  logic                valid;
  logic                ready;
  lesq_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

[src/lesq_line_buf.sv]
// Line buffer holding the square sizes of the row above.
// One write port and one read port with registered read data; no dependencies.
module lesq_line_buf #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 11,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the contents before a write at the same edge.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

[src/largest_empty_square_scan_top.sv]
// Largest empty square scanner: top level with configuration, position
// tracking, the size recurrence and the result register. Depends on lesq_pkg,
// lesq_if and lesq_line_buf.

// The block takes one map character per clock in row-major order and returns
// one result per character, sustaining one cell per cycle while the result
// channel is not stalled. An accepted transfer is loaded into the compute
// stage and from there moves on into the output register. The rate is set by
// the line buffer, which serves one read (the size above the incoming cell,
// fetched at acceptance) and one write (the size of the cell being finished)
// at once, and by the single stage holding the three-way minimum and the best
// compare. The line buffer is not cleared after reset; the first row of a map
// never uses what it reads there, so no clearing pass is needed. Configuration
// may be written only while no transfer is in flight.
module largest_empty_square_scan_top #(
  parameter int MAX_COLS = lesq_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = lesq_pkg::DEF_MAX_ROWS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lesq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lesq_pkg::CFG_DATA_W-1:0] cfg_data,
  lesq_in_if.sink                         in_ch,
  lesq_out_if.source                      out_ch
);

  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int MIN_DIM = (MAX_ROWS < MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int SIZE_W  = $clog2(MIN_DIM + 1);
  localparam int POS_W   = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int CNT_W   = (lesq_pkg::COUNT_W > POS_W + 1) ? lesq_pkg::COUNT_W : POS_W + 1;

  // Configuration registers.
  logic [lesq_pkg::COUNT_W-1:0] row_count;
  logic [lesq_pkg::COUNT_W-1:0] column_count;
  logic [lesq_pkg::CHAR_W-1:0]  obstacle_code;
  logic [lesq_pkg::CHAR_W-1:0]  free_code;

  // Scan position of the next cell to arrive.
  logic [COL_W-1:0] col_pos;
  logic [ROW_W-1:0] row_pos;

  // Compute stage, loaded at input transfer.
  logic             s1_valid;
  logic [COL_W-1:0] s1_col;
  logic [ROW_W-1:0] s1_row;
  logic             s1_cell;
  logic             s1_bad;
  logic             s1_last_col;
  logic             s1_last_row;

  // Recurrence and best-square state.
  logic [SIZE_W-1:0] left_size;
  logic [SIZE_W-1:0] diagonal_size;
  logic [SIZE_W-1:0] best_side;
  logic [ROW_W-1:0]  best_row_pos;
  logic [COL_W-1:0]  best_col_pos;

  // Result register.
  logic                out_valid;
  lesq_pkg::out_item_t out_item;

  logic              in_fire;
  logic              s1_adv;
  logic              s1_fire;
  logic [CNT_W-1:0]  rows_raw;
  logic [CNT_W-1:0]  cols_raw;
  logic [CNT_W-1:0]  rows_eff;
  logic [CNT_W-1:0]  cols_eff;
  logic              last_col;
  logic              last_row;
  logic              is_obstacle;
  logic              is_free;
  logic [SIZE_W-1:0] up_size;
  logic [SIZE_W-1:0] min_lu;
  logic [SIZE_W-1:0] min_all;
  logic [SIZE_W-1:0] size;
  logic              improve;
  logic [SIZE_W-1:0] best_side_next;
  logic [ROW_W-1:0]  best_row_next;
  logic [COL_W-1:0]  best_col_next;
  logic              done;

  // Handshakes: the compute stage moves on whenever the result register is
  // free or is being emptied.
  assign s1_adv      = !out_valid || out_ch.ready;
  assign s1_fire     = s1_valid && s1_adv;
  assign in_ch.ready = !s1_valid || s1_adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count     <= lesq_pkg::RST_ROW_COUNT;
      column_count  <= lesq_pkg::RST_COLUMN_COUNT;
      obstacle_code <= lesq_pkg::RST_OBSTACLE_CODE;
      free_code     <= lesq_pkg::RST_FREE_CODE;
    end else if (cfg_we) begin
      case (cfg_index)
        lesq_pkg::REG_ROW_COUNT:     row_count     <= cfg_data;
        lesq_pkg::REG_COLUMN_COUNT:  column_count  <= cfg_data;
        lesq_pkg::REG_OBSTACLE_CODE: obstacle_code <= cfg_data[lesq_pkg::CHAR_W-1:0];
        lesq_pkg::REG_FREE_CODE:     free_code     <= cfg_data[lesq_pkg::CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective map dimensions: zero acts as one, large values stop at the limit.
  always_comb begin
    rows_raw = CNT_W'(row_count);
    cols_raw = CNT_W'(column_count);
    if (rows_raw == '0) begin
      rows_eff = CNT_W'(1);
    end else if (rows_raw > CNT_W'(MAX_ROWS)) begin
      rows_eff = CNT_W'(MAX_ROWS);
    end else begin
      rows_eff = rows_raw;
    end
    if (cols_raw == '0) begin
      cols_eff = CNT_W'(1);
    end else if (cols_raw > CNT_W'(MAX_COLS)) begin
      cols_eff = CNT_W'(MAX_COLS);
    end else begin
      cols_eff = cols_raw;
    end
  end

  // A position at or past the last row or column counts as the last.
  assign last_col = (CNT_W'(col_pos) + CNT_W'(1)) >= cols_eff;
  assign last_row = (CNT_W'(row_pos) + CNT_W'(1)) >= rows_eff;

  // Character classification; an obstacle match wins over a free match.
  assign is_obstacle = (in_ch.cell_char == obstacle_code);
  assign is_free     = (in_ch.cell_char == free_code);

  // Position counters advance with each input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (in_fire) begin
      if (last_col && last_row) begin
        col_pos <= '0;
        row_pos <= '0;
      end else if (last_col) begin
        col_pos <= '0;
        row_pos <= row_pos + ROW_W'(1);
      end else begin
        col_pos <= col_pos + COL_W'(1);
      end
    end
  end

  // Compute stage valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_fire;
    end
  end

  // Compute stage payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_col      <= col_pos;
      s1_row      <= row_pos;
      s1_cell     <= !is_obstacle && is_free;
      s1_bad      <= !is_obstacle && !is_free;
      s1_last_col <= last_col;
      s1_last_row <= last_row;
    end
  end

  // Sizes of the row above. The read for a cell is issued at its transfer;
  // the write of the finished cell lands at the same edge. They meet at one
  // address only in single-column maps, where the size above is never used.
  lesq_line_buf #(
    .DEPTH (MAX_COLS),
    .WIDTH (SIZE_W)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (col_pos),
    .rd_data (up_size),
    .wr_en   (s1_fire),
    .wr_addr (s1_col),
    .wr_data (size)
  );

  // Square size recurrence and best-square update.
  always_comb begin
    min_lu  = (left_size < up_size) ? left_size : up_size;
    min_all = (diagonal_size < min_lu) ? diagonal_size : min_lu;
    if (s1_row == '0 || s1_col == '0 || !s1_cell) begin
      size = SIZE_W'(s1_cell);
    end else begin
      size = min_all + SIZE_W'(1);
    end
    improve = size > best_side;
    if (improve) begin
      best_side_next = size;
      best_row_next  = s1_row;
      best_col_next  = s1_col;
    end else begin
      best_side_next = best_side;
      best_row_next  = best_row_pos;
      best_col_next  = best_col_pos;
    end
    done = s1_last_col && s1_last_row;
  end

  // Recurrence state: neighbors clear at row end, best values at map end.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_size     <= '0;
      diagonal_size <= '0;
      best_side     <= '0;
      best_row_pos  <= '0;
      best_col_pos  <= '0;
    end else if (s1_fire) begin
      left_size     <= s1_last_col ? '0 : size;
      diagonal_size <= s1_last_col ? '0 : up_size;
      if (done) begin
        best_side    <= '0;
        best_row_pos <= '0;
        best_col_pos <= '0;
      end else begin
        best_side    <= best_side_next;
        best_row_pos <= best_row_next;
        best_col_pos <= best_col_next;
      end
    end
  end

  // Result register valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_item.square_size <= lesq_pkg::SIZE_OUT_W'(size);
      out_item.best_size   <= lesq_pkg::SIZE_OUT_W'(best_side_next);
      out_item.best_row    <= lesq_pkg::POS_OUT_W'(best_row_next);
      out_item.best_col    <= lesq_pkg::POS_OUT_W'(best_col_next);
      out_item.bad_char    <= s1_bad;
      out_item.map_done    <= done;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.item  = out_item;

endmodule

[src/lesq_checker.sv]
// Port-level checks on the scanner's result channel, bound to the top level.
// Depends on lesq_pkg for the result item type.
module lesq_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input lesq_pkg::out_item_t out_item
);

  // Reset drops any pending result.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds its contents.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // The best size already includes the current cell.
  a_best_covers: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.best_size >= out_item.square_size)
    else $error("best size below current square");

  // An unknown character is blocked, so it ends no square.
  a_bad_blocked: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.bad_char |-> out_item.square_size == '0)
    else $error("square on an unknown character");

  // With no square found yet the corner stays at the origin.
  a_empty_origin: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.best_size == '0 |->
      out_item.best_row == '0 && out_item.best_col == '0)
    else $error("corner moved without a square");

endmodule

bind largest_empty_square_scan_top lesq_checker u_lesq_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_item  (out_ch.item)
);

[tb/sv/lesq_scan_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the largest empty square scanner: follows register writes,
// predicts one result per accepted map character and checks every result.
// Depends on lesq_pkg and the channel interfaces of lesq_if.
module lesq_scan_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lesq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lesq_pkg::CFG_DATA_W-1:0] cfg_data,
  lesq_in_if                              cells_mon,
  lesq_out_if                             results_mon,
  output int                              fail_count,
  output int                              pending
);
  import lesq_pkg::*;

  // Register copies.
  logic [COUNT_W-1:0] rows_cfg;
  logic [COUNT_W-1:0] cols_cfg;
  logic [CHAR_W-1:0]  blocked_code;
  logic [CHAR_W-1:0]  empty_code;

  // Scan state: sizes of the row above, running neighbors, position and best square.
  logic [SIZE_OUT_W-1:0] above_sizes [DEF_MAX_COLS];
  logic [SIZE_OUT_W-1:0] size_left;
  logic [SIZE_OUT_W-1:0] size_diag;
  logic [SIZE_OUT_W-1:0] top_side;
  logic [POS_OUT_W-1:0]  at_row;
  logic [POS_OUT_W-1:0]  at_col;
  logic [POS_OUT_W-1:0]  top_row;
  logic [POS_OUT_W-1:0]  top_col;

  out_item_t expected_scan[$];
  out_item_t want;
  int        errors = 0;

  // A count of zero means one; anything above the map limit means the limit.
  function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v,
                                                     input int limit);
    if (v == '0) return COUNT_W'(1);
    if (v > limit) return COUNT_W'(limit);
    return v;
  endfunction

  function automatic void start_map();
    size_left = '0;
    size_diag = '0;
    at_row    = '0;
    at_col    = '0;
    top_side  = '0;
    top_row   = '0;
    top_col   = '0;
  endfunction

  // Square size recurrence for one cell, plus best tracking and position update.
  function automatic out_item_t next_square(input logic [CHAR_W-1:0] ch);
    logic [COUNT_W-1:0]    rows_eff;
    logic [COUNT_W-1:0]    cols_eff;
    logic [SIZE_OUT_W-1:0] up;
    logic [SIZE_OUT_W-1:0] size;
    logic [SIZE_OUT_W-1:0] shortest;
    logic                  is_free;
    logic                  is_bad;
    logic                  row_end;
    logic                  map_end;
    out_item_t             res;
    rows_eff = clamp_count(rows_cfg, DEF_MAX_ROWS);
    cols_eff = clamp_count(cols_cfg, DEF_MAX_COLS);

    // The obstacle code wins when both codes are the same.
    if (ch == blocked_code) begin
      is_free = 1'b0;
      is_bad  = 1'b0;
    end else if (ch == empty_code) begin
      is_free = 1'b1;
      is_bad  = 1'b0;
    end else begin
      is_free = 1'b0;
      is_bad  = 1'b1;
    end

    up = above_sizes[at_col];
    if (at_row == '0 || at_col == '0 || !is_free) begin
      size = SIZE_OUT_W'(is_free);
    end else begin
      shortest = size_left;
      if (up < shortest) shortest = up;
      if (size_diag < shortest) shortest = size_diag;
      size = shortest + 1'b1;
    end
    size_diag           = up;
    above_sizes[at_col] = size;
    size_left           = size;

    // Only a strict improvement moves the best corner.
    if (size > top_side) begin
      top_side = size;
      top_row  = at_row;
      top_col  = at_col;
    end

    // A position at or past the last column or row counts as the last one.
    row_end = (COUNT_W'(at_col) + 1'b1 >= cols_eff);
    map_end = row_end && (COUNT_W'(at_row) + 1'b1 >= rows_eff);

    res.square_size = size;
    res.best_size   = top_side;
    res.best_row    = top_row;
    res.best_col    = top_col;
    res.bad_char    = is_bad;
    res.map_done    = map_end;

    if (map_end) begin
      start_map();
    end else if (row_end) begin
      at_col    = '0;
      at_row    = at_row + 1'b1;
      size_left = '0;
      size_diag = '0;
    end else begin
      at_col = at_col + 1'b1;
    end
    return res;
  endfunction

  // Printing stops after a couple hundred mismatches; counting does not.
  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned got_v);
    if (exp_v != got_v) begin
      errors++;
      if (errors <= 200) $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
    end
  endfunction

  // Register writes, result checks and predictions, all sampled at the edge.
  always @(posedge clk) begin
    if (rst) begin
      rows_cfg     = RST_ROW_COUNT;
      cols_cfg     = RST_COLUMN_COUNT;
      blocked_code = RST_OBSTACLE_CODE;
      empty_code   = RST_FREE_CODE;
      foreach (above_sizes[i]) above_sizes[i] = '0;
      start_map();
      expected_scan.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ROW_COUNT:     rows_cfg = cfg_data;
          REG_COLUMN_COUNT:  cols_cfg = cfg_data;
          REG_OBSTACLE_CODE: blocked_code = cfg_data[CHAR_W-1:0];
          REG_FREE_CODE:     empty_code = cfg_data[CHAR_W-1:0];
          default: ;
        endcase
      end

      // Result transfer: compare against the oldest prediction.
      if (results_mon.valid && results_mon.ready) begin
        if (expected_scan.size() == 0) begin
          errors++;
          if (errors <= 200) $error("Result transfer with no character outstanding");
        end else begin
          want = expected_scan.pop_front();
          check_field("square_size", want.square_size, results_mon.item.square_size);
          check_field("best_size", want.best_size, results_mon.item.best_size);
          check_field("best_row", want.best_row, results_mon.item.best_row);
          check_field("best_col", want.best_col, results_mon.item.best_col);
          check_field("bad_char", want.bad_char, results_mon.item.bad_char);
          check_field("map_done", want.map_done, results_mon.item.map_done);
        end
      end

      // Character transfer: predict its result.
      if (cells_mon.valid && cells_mon.ready) begin
        expected_scan.push_back(next_square(cells_mon.cell_char));
      end
    end
    pending    <= expected_scan.size();
    fail_count <= errors;
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// Top of the scanner testbench: clock, reset, register writes, map character
// stimulus, result back-pressure and the verdict. Depends on lesq_pkg, lesq_if,
// the scanner top level and lesq_scan_checker.
module testbench;
  import lesq_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;

  // Stimulus bookkeeping: last written register values and character mix.
  int                cur_rows;
  int                cur_cols;
  logic [CHAR_W-1:0] cur_obst;
  logic [CHAR_W-1:0] cur_free;
  int                free_pct;
  int                bad_pct;
  bit                burst;
  int                cells_sent;
  int                maps_sent;

  lesq_in_if  cells_ch();
  lesq_out_if results_ch();

  largest_empty_square_scan_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (cells_ch),
    .out_ch    (results_ch)
  );

  lesq_scan_checker scan_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cells_mon   (cells_ch),
    .results_mon (results_ch),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int eff_count(input int v, input int limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  // Free cells, obstacles and unknown characters, mixed by free_pct and bad_pct.
  function automatic logic [CHAR_W-1:0] pick_char();
    int                r;
    logic [CHAR_W-1:0] ch;
    r = $urandom_range(0, 99);
    if (r < free_pct) return cur_free;
    if (r >= free_pct + bad_pct) return cur_obst;
    ch = CHAR_W'($urandom_range(0, 255));
    // Keep unknown characters off the free code so a cell is free only by choice.
    if (ch == cur_free) ch = ch ^ 8'h80;
    return ch;
  endfunction

  // One character transfer, after a random gap unless in a burst.
  task automatic send_cell(input logic [CHAR_W-1:0] ch);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 65) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 10);
    else gap = $urandom_range(15, 30);
    if (gap > 0) begin
      cells_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cells_ch.valid     <= 1'b1;
    cells_ch.cell_char <= ch;
    do @(posedge clk); while (!cells_ch.ready);
    cells_sent++;
  endtask

  // Drain every outstanding result, then let the pipeline settle.
  task automatic wait_idle();
    cells_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Size registers are written only when they change, so equal maps stream back to back.
  task automatic set_size(input int rows_w, input int cols_w);
    if (rows_w != cur_rows || cols_w != cur_cols) begin
      wait_idle();
      if (rows_w != cur_rows) write_reg(REG_ROW_COUNT, CFG_DATA_W'(rows_w));
      if (cols_w != cur_cols) write_reg(REG_COLUMN_COUNT, CFG_DATA_W'(cols_w));
      cur_rows = rows_w;
      cur_cols = cols_w;
    end
  endtask

  // Code writes may carry junk in the upper data bits, which the block drops.
  task automatic set_codes(input logic [CHAR_W-1:0] obst, input logic [CHAR_W-1:0] free,
                           input logic [2:0] pad);
    wait_idle();
    write_reg(REG_OBSTACLE_CODE, {pad, obst});
    write_reg(REG_FREE_CODE, {pad, free});
    cur_obst = obst;
    cur_free = free;
  endtask

  // One map of random cells. With a split, the sizes change after that many
  // cells and the rest of the map follows the new sizes from the current position.
  task automatic scan_map(input int rows_w, input int cols_w, input int split,
                          input int split_rows_w, input int split_cols_w);
    int rows_e;
    int cols_e;
    int total;
    int r;
    int c;
    set_size(rows_w, cols_w);
    rows_e = eff_count(rows_w, DEF_MAX_ROWS);
    cols_e = eff_count(cols_w, DEF_MAX_COLS);
    total  = rows_e * cols_e;
    if (split > 0 && split < total) begin
      repeat (split) send_cell(pick_char());
      r = split / cols_e;
      c = split % cols_e;
      set_size(split_rows_w, split_cols_w);
      rows_e = eff_count(split_rows_w, DEF_MAX_ROWS);
      cols_e = eff_count(split_cols_w, DEF_MAX_COLS);
      total  = ((c >= cols_e - 1) ? 1 : cols_e - c) +
               ((r + 1 >= rows_e) ? 0 : (rows_e - 1 - r) * cols_e);
    end
    repeat (total) send_cell(pick_char());
    maps_sent++;
  endtask

  // Result side back-pressure: short random stalls, full-speed stretches and
  // a periodic long hold so the block fills up and stalls its input.
  initial begin
    int cycle_no;
    int hold_left;
    int stall_left;
    int r;
    bit steady;
    cycle_no   = 0;
    hold_left  = 0;
    stall_left = 0;
    steady     = 1'b0;
    results_ch.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      cycle_no++;
      if (cycle_no % 128 == 0) steady = ($urandom_range(0, 3) == 0);
      if (cycle_no % 4000 == 1500) hold_left = 300;
      if (hold_left > 0) begin
        hold_left--;
        results_ch.ready <= 1'b0;
      end else if (steady) begin
        results_ch.ready <= 1'b1;
      end else begin
        if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
          r = $urandom_range(0, 99);
          if (r < 70) stall_left = $urandom_range(1, 3);
          else if (r < 95) stall_left = $urandom_range(4, 10);
          else stall_left = $urandom_range(15, 30);
        end
        if (stall_left > 0) begin
          stall_left--;
          results_ch.ready <= 1'b0;
        end else begin
          results_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timed out with %0d results outstanding", pending);
    $display("FAILURE");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    logic [CHAR_W-1:0] corner_map [12] = '{8'hFF, 8'hFF, 8'hFF, 8'h00,
                                           8'hFF, 8'hFF, 8'hFF, 8'h5A,
                                           8'hFF, 8'hFF, 8'hFF, 8'hA5};
    logic [CHAR_W-1:0] same_code_map [3] = '{8'h2E, 8'h2E, 8'h41};
    logic [CHAR_W-1:0] obst;
    int start_cells;
    int rows_w;
    int cols_w;
    int split;
    int split_rows;
    int split_cols;
    int total;

    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = REG_ROW_COUNT;
    cfg_data           = '0;
    cells_ch.valid     = 1'b0;
    cells_ch.cell_char = '0;
    cur_rows           = RST_ROW_COUNT;
    cur_cols           = RST_COLUMN_COUNT;
    cur_obst           = RST_OBSTACLE_CODE;
    cur_free           = RST_FREE_CODE;
    burst              = 1'b0;
    cells_sent         = 0;
    maps_sent          = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // One full-width row: every line buffer entry gets written before any row
    // reads it. Row count 0 acts as one, column count 2047 as the maximum.
    // Only the last cell is free, so the best corner lands in the last column.
    free_pct = 0;
    bad_pct  = 30;
    set_size(0, 2047);
    repeat (DEF_MAX_COLS - 1) send_cell(pick_char());
    send_cell(cur_free);
    maps_sent++;

    // One full-height column, clamped counts the other way round.
    set_size(2047, 0);
    repeat (DEF_MAX_ROWS - 1) send_cell(pick_char());
    send_cell(cur_free);
    maps_sent++;

    // Extreme character codes, a 3x3 square and unknown characters.
    set_codes(8'h00, 8'hFF, 3'd0);
    set_size(3, 4);
    foreach (corner_map[i]) send_cell(corner_map[i]);
    maps_sent++;

    // Free and obstacle codes equal: the obstacle reading wins.
    set_codes(8'h2E, 8'h2E, 3'd0);
    set_size(1, 3);
    foreach (same_code_map[i]) send_cell(same_code_map[i]);
    maps_sent++;

    // Width cut mid-map: the current cell becomes the last of the map.
    set_codes(RST_OBSTACLE_CODE, RST_FREE_CODE, 3'd0);
    free_pct = 100;
    bad_pct  = 0;
    scan_map(2, 4, 5, 2, 2);

    // Random maps: mostly small, with code changes and mid-map size changes.
    start_cells = cells_sent;
    rows_w      = 4;
    cols_w      = 4;
    while (cells_sent - start_cells < 500) begin
      if ($urandom_range(0, 5) == 0) begin
        obst = CHAR_W'($urandom_range(0, 255));
        set_codes(obst, ($urandom_range(0, 15) == 0) ? obst : CHAR_W'($urandom_range(0, 255)),
                  3'($urandom_range(0, 7)));
      end
      burst    = ($urandom_range(0, 3) == 0);
      free_pct = $urandom_range(55, 95);
      bad_pct  = $urandom_range(0, 10);
      if ($urandom_range(0, 2) != 0) begin
        rows_w = $urandom_range(1, 10);
        cols_w = $urandom_range(1, 12);
        if ($urandom_range(0, 19) == 0) rows_w = 0;
        if ($urandom_range(0, 19) == 0) cols_w = 0;
        if ($urandom_range(0, 29) == 0) cols_w = $urandom_range(13, 80);
      end
      split      = 0;
      split_rows = rows_w;
      split_cols = cols_w;
      total      = eff_count(rows_w, DEF_MAX_ROWS) * eff_count(cols_w, DEF_MAX_COLS);
      if (total > 1 && $urandom_range(0, 5) == 0) begin
        split = $urandom_range(1, total - 1);
        if ($urandom_range(0, 1) == 0) split_cols = $urandom_range(0, 12);
        else split_rows = $urandom_range(0, 10);
      end
      scan_map(rows_w, cols_w, split, split_rows, split_cols);
    end
    burst = 1'b0;

    // Let every result come back, then wait on for stray transfers.
    cells_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);

    $display("Scanned %0d cells in %0d maps, among them a full-width row and a full-height column,",
             cells_sent, maps_sent);
    $display("with clamped counts, equal and random codes, unknown characters and mid-map resizes.");
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[largest_empty_square_scan_top.f]
src/lesq_pkg.sv
src/lesq_if.sv
src/lesq_line_buf.sv
src/largest_empty_square_scan_top.sv
src/lesq_checker.sv
tb/sv/lesq_scan_checker.sv
tb/sv/testbench.sv
